/* rtl/dap_pkg.sv */
// ----------------------------------------------------------------------------
// DNS answer address parser package
// Types and constants shared by the parser, its channels and its checker.
// ----------------------------------------------------------------------------
package dap_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  status_t;
    typedef logic [31:0] addr_t;
    typedef logic [15:0] word_t;
    typedef logic [5:0]  label_t;
    typedef logic [3:0]  field_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QPTR   = 4'd2,
        PH_QTAIL  = 4'd3,
        PH_ANAME  = 4'd4,
        PH_APTR   = 4'd5,
        PH_FIXED  = 4'd6,
        PH_ADDR   = 4'd7,
        PH_SKIP   = 4'd8,
        PH_DONE   = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        OUT_UNDECIDED = 2'd0,
        OUT_FOUND     = 2'd1,
        OUT_NONE      = 2'd2
    } outcome_t;

    localparam status_t STATUS_FOUND     = 2'd0;
    localparam status_t STATUS_NO_ANSWER = 2'd1;
    localparam status_t STATUS_SHORT     = 2'd2;

    localparam int HDR_ANCOUNT_HI = 6;
    localparam int HDR_ANCOUNT_LO = 7;
    localparam int HDR_LAST       = 11;

    localparam field_t QTAIL_LAST   = 4'd3;
    localparam field_t FIX_TYPE_HI  = 4'd0;
    localparam field_t FIX_TYPE_LO  = 4'd1;
    localparam field_t FIX_RDLEN_HI = 4'd8;
    localparam field_t FIX_RDLEN_LO = 4'd9;
    localparam field_t ADDR_LAST    = 4'd3;

    localparam word_t TYPE_A     = 16'd1;
    localparam word_t RDLEN_IPV4 = 16'd4;

endpackage

/* rtl/dap_if.sv */
// ----------------------------------------------------------------------------
// DNS answer address parser channels
// Valid/ready channels for message bytes in and parse results out.
// ----------------------------------------------------------------------------
interface dap_msg_if;
    logic            valid;
    logic            ready;
    dap_pkg::byte_t  resp_byte;
    logic            last_byte;

    modport source (output valid, output resp_byte, output last_byte, input ready);
    modport sink   (input valid, input resp_byte, input last_byte, output ready);
endinterface

interface dap_res_if;
    logic             valid;
    logic             ready;
    dap_pkg::status_t status;
    dap_pkg::addr_t   address;

    modport source (output valid, output status, output address, input ready);
    modport sink   (input valid, input status, input address, output ready);
endinterface

/* rtl/dns_answer_address_parser.sv */
// ----------------------------------------------------------------------------
// DNS answer address parser
// Walks a DNS response one byte per item and reports the first IPv4 address.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle while input is not held back
// and returns one result item per message from its result register.
// Each byte passes through an input register, a parse-state update and,
// for the final byte, a result register. Input is held back only while a
// result waits to be taken and the next final byte is already registered.
// Bytes beyond MAX_MSG_BYTES are not parsed, but the final byte still ends
// the message.
module dns_answer_address_parser
    import dap_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 512
)
(
    input  logic      clk,
    input  logic      rst_n,
    dap_msg_if.sink   msg,
    dap_res_if.source res
);

    localparam int CNT_W = $clog2(MAX_MSG_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MSG_BYTES);

    logic             in_valid_reg;
    byte_t            in_byte_reg;
    logic             in_last_reg;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    word_t            answers_reg, answers_next;
    label_t           label_reg, label_next;
    field_t           field_reg, field_next;
    word_t            rtype_reg, rtype_next;
    word_t            rdata_reg, rdata_next;
    addr_t            accum_reg, accum_next;
    outcome_t         outcome_reg, outcome_next;

    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    addr_t            address_reg, address_next;

    logic             stall;
    logic             consume;
    logic             name_end;
    logic             name_ptr;
    label_t           label_upd;
    word_t            rdata_full;
    word_t            answers_dec;

    assign stall   = in_valid_reg && in_last_reg && out_valid_reg && !res.ready;
    assign consume = in_valid_reg && !stall;
    assign msg.ready = !stall;

    assign res.valid   = out_valid_reg;
    assign res.status  = status_reg;
    assign res.address = address_reg;

    assign name_end    = (label_reg == '0) && (in_byte_reg == '0);
    assign name_ptr    = (label_reg == '0) && (in_byte_reg[7:6] != 2'b00);
    assign label_upd   = (label_reg != '0) ? label_t'(label_reg - 1'b1)
                       : ((in_byte_reg[7:6] != 2'b00) ? '0 : in_byte_reg[5:0]);
    assign rdata_full  = {rdata_reg[15:8], in_byte_reg};
    assign answers_dec = word_t'(answers_reg - 1'b1);

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        answers_next   = answers_reg;
        label_next     = label_reg;
        field_next     = field_reg;
        rtype_next     = rtype_reg;
        rdata_next     = rdata_reg;
        accum_next     = accum_reg;
        outcome_next   = outcome_reg;
        out_valid_next = out_valid_reg && !res.ready;
        status_next    = status_reg;
        address_next   = address_reg;

        if (consume)
        begin
            if (count_reg < CNT_MAX)
            begin
                count_next = CNT_W'(count_reg + 1'b1);
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (count_reg == CNT_W'(HDR_ANCOUNT_HI))
                        begin
                            answers_next = {in_byte_reg, 8'h00};
                        end
                        else if (count_reg == CNT_W'(HDR_ANCOUNT_LO))
                        begin
                            answers_next = {answers_reg[15:8], in_byte_reg};
                        end
                        if (count_reg == CNT_W'(HDR_LAST))
                        begin
                            if (answers_reg == '0)
                            begin
                                outcome_next = OUT_NONE;
                                phase_next   = PH_DONE;
                            end
                            else
                            begin
                                label_next = '0;
                                phase_next = PH_QNAME;
                            end
                        end
                    end
                    PH_QNAME, PH_ANAME:
                    begin
                        label_next = label_upd;
                        if (name_end)
                        begin
                            field_next = '0;
                            phase_next = (phase_reg == PH_QNAME) ? PH_QTAIL : PH_FIXED;
                        end
                        else if (name_ptr)
                        begin
                            phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                        end
                    end
                    PH_QPTR:
                    begin
                        field_next = '0;
                        phase_next = PH_QTAIL;
                    end
                    PH_APTR:
                    begin
                        field_next = '0;
                        phase_next = PH_FIXED;
                    end
                    PH_QTAIL:
                    begin
                        if (field_reg >= QTAIL_LAST)
                        begin
                            label_next = '0;
                            phase_next = PH_ANAME;
                        end
                        else
                        begin
                            field_next = field_t'(field_reg + 1'b1);
                        end
                    end
                    PH_FIXED:
                    begin
                        if (field_reg == FIX_TYPE_HI)
                        begin
                            rtype_next = {in_byte_reg, 8'h00};
                        end
                        else if (field_reg == FIX_TYPE_LO)
                        begin
                            rtype_next = {rtype_reg[15:8], in_byte_reg};
                        end
                        else if (field_reg == FIX_RDLEN_HI)
                        begin
                            rdata_next = {in_byte_reg, 8'h00};
                        end
                        else if (field_reg == FIX_RDLEN_LO)
                        begin
                            rdata_next = rdata_full;
                        end
                        if (field_reg < FIX_RDLEN_LO)
                        begin
                            field_next = field_t'(field_reg + 1'b1);
                        end
                        else if (rtype_reg == TYPE_A && rdata_full == RDLEN_IPV4)
                        begin
                            field_next = '0;
                            accum_next = '0;
                            phase_next = PH_ADDR;
                        end
                        else
                        begin
                            answers_next = answers_dec;
                            if (answers_dec == '0)
                            begin
                                outcome_next = OUT_NONE;
                                phase_next   = PH_DONE;
                            end
                            else if (rdata_full == '0)
                            begin
                                label_next = '0;
                                phase_next = PH_ANAME;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_ADDR:
                    begin
                        accum_next = {accum_reg[23:0], in_byte_reg};
                        if (field_reg >= ADDR_LAST)
                        begin
                            outcome_next = OUT_FOUND;
                            phase_next   = PH_DONE;
                        end
                        else
                        begin
                            field_next = field_t'(field_reg + 1'b1);
                        end
                    end
                    PH_SKIP:
                    begin
                        rdata_next = word_t'(rdata_reg - 1'b1);
                        if (rdata_reg == 16'd1)
                        begin
                            label_next = '0;
                            phase_next = PH_ANAME;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            if (in_last_reg)
            begin
                out_valid_next = 1'b1;
                case (outcome_next)
                    OUT_FOUND:
                    begin
                        status_next  = STATUS_FOUND;
                        address_next = accum_next;
                    end
                    OUT_NONE:
                    begin
                        status_next  = STATUS_NO_ANSWER;
                        address_next = '0;
                    end
                    default:
                    begin
                        status_next  = STATUS_SHORT;
                        address_next = '0;
                    end
                endcase
                phase_next   = PH_HEADER;
                count_next   = '0;
                answers_next = '0;
                label_next   = '0;
                field_next   = '0;
                rtype_next   = '0;
                rdata_next   = '0;
                accum_next   = '0;
                outcome_next = OUT_UNDECIDED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            count_reg     <= '0;
            answers_reg   <= '0;
            label_reg     <= '0;
            field_reg     <= '0;
            rtype_reg     <= '0;
            rdata_reg     <= '0;
            accum_reg     <= '0;
            outcome_reg   <= OUT_UNDECIDED;
        end
        else
        begin
            if (!stall)
            begin
                in_valid_reg <= msg.valid;
            end
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            answers_reg   <= answers_next;
            label_reg     <= label_next;
            field_reg     <= field_next;
            rtype_reg     <= rtype_next;
            rdata_reg     <= rdata_next;
            accum_reg     <= accum_next;
            outcome_reg   <= outcome_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && !stall)
        begin
            in_byte_reg <= msg.resp_byte;
            in_last_reg <= msg.last_byte;
        end
        status_reg  <= status_next;
        address_reg <= address_next;
    end

endmodule

/* rtl/dap_checker.sv */
// ----------------------------------------------------------------------------
// DNS answer address parser checker
// Port-level properties of the parser, attached to every instance by bind.
// ----------------------------------------------------------------------------
module dap_checker
    import dap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_ready,
    input  logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    input  addr_t   address
);

    // Input is only ever held back while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with no result waiting");

    // A failed parse never carries an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_FOUND |-> address == '0)
        else $error("address reported without a found status");

    // Status takes one of its three defined values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_FOUND || status == STATUS_NO_ANSWER
                      || status == STATUS_SHORT)
        else $error("undefined status reported");

    // A result that is not taken holds steady.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(address))
        else $error("waiting result changed");

endmodule

bind dns_answer_address_parser dap_checker u_dap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (msg.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (res.status),
    .address   (res.address)
);
